/* rtl/core/windowed_climb_rate_defines.svh */
`ifndef WINDOWED_CLIMB_RATE_DEFINES_SVH
`define WINDOWED_CLIMB_RATE_DEFINES_SVH

// same-cycle implication
`define WCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define WCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/core/wcr_pkg.sv */
package wcr_pkg;

	localparam int MUL_STEPS = 34;
	localparam int DIV_STEPS = 75;
	localparam logic [7:0] WINDOW_RESET = 8'd10;
	localparam logic signed [33:0] RATE_SCALE = 34'sd960;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PREV_RD,
		ST_PREV_WT,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_DECIDE,
		ST_LEFT_WT,
		ST_INTERP_WT,
		ST_RATE,
		ST_RATE_WT,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	typedef struct packed {
		logic load;
		logic clamp;
		logic rd_prev;
		logic use_prev;
		logic rd_trail;
		logic walk_step;
		logic take_t1;
		logic use_t1;
		logic rd_left;
		logic left_take;
		logic interp_start;
		logic interp_done;
		logic set_zero;
		logic rate_start;
		logic rate_done;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic win_zero;
		logic walk_more;
		logic at_edge;
		logic left_equal;
		logic dt_zero;
		logic md_done;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/wcr_muldiv.sv */
module wcr_muldiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [41:0]  x,
	input  logic signed [33:0]  y,
	input  logic signed [33:0]  d,
	output logic                done,
	output logic signed [75:0]  q
);

	wcr_pkg::md_state_t state_q, state_nxt;
	logic [6:0]  cnt_q;
	logic        sgn_q;
	logic [74:0] mcand_q;
	logic [33:0] mplier_q;
	logic [74:0] prod_q;
	logic [33:0] dmag_q;
	logic [33:0] rem_q;
	logic        done_q;
	logic [41:0] xmag;
	logic [33:0] ymag;
	logic [33:0] dmag;
	logic [34:0] trial;
	logic        fit;

	assign xmag  = x[41] ? 42'(-x) : 42'(x);
	assign ymag  = y[33] ? 34'(-y) : 34'(y);
	assign dmag  = d[33] ? 34'(-d) : 34'(d);
	assign trial = {rem_q, prod_q[74]};
	assign fit   = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcr_pkg::MD_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wcr_pkg::MD_IDLE: begin
				if (start) state_nxt = wcr_pkg::MD_MUL;
			end
			wcr_pkg::MD_MUL: begin
				if (cnt_q == 7'(wcr_pkg::MUL_STEPS - 1)) state_nxt = wcr_pkg::MD_DIV;
			end
			wcr_pkg::MD_DIV: begin
				if (cnt_q == 7'(wcr_pkg::DIV_STEPS - 1)) state_nxt = wcr_pkg::MD_IDLE;
			end
			default: state_nxt = wcr_pkg::MD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (state_q == wcr_pkg::MD_DIV) &&
				(cnt_q == 7'(wcr_pkg::DIV_STEPS - 1));
			if (state_q != state_nxt) cnt_q <= '0;
			else if (state_q != wcr_pkg::MD_IDLE) cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wcr_pkg::MD_IDLE: begin
				if (start) begin
					sgn_q    <= x[41] ^ y[33] ^ d[33];
					mcand_q  <= 75'(xmag);
					mplier_q <= ymag;
					dmag_q   <= dmag;
					prod_q   <= '0;
					rem_q    <= '0;
				end
			end
			wcr_pkg::MD_MUL: begin
				if (mplier_q[0]) prod_q <= prod_q + mcand_q;
				mcand_q  <= {mcand_q[73:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[33:1]};
			end
			wcr_pkg::MD_DIV: begin
				rem_q  <= fit ? 34'(trial - {1'b0, dmag_q}) : trial[33:0];
				prod_q <= {prod_q[73:0], fit};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign q    = sgn_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});

endmodule

/* rtl/core/wcr_dpath.sv */
module wcr_dpath #(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         t_in,
	input  logic [23:0]         a_in,
	input  logic                start_in,
	input  logic                cfg_wen,
	input  logic [7:0]          cfg_wdata,
	input  wcr_pkg::cmd_t       cmd,
	output wcr_pkg::sts_t       sts,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,
	output logic [1:0]          m_tuser
);

	localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam logic [SW-1:0] SLOT_MAX = SW'(HISTORY_DEPTH - 1);
	localparam logic [31:0] DEPTH_M1 = 32'(HISTORY_DEPTH - 1);

	logic [31:0] time_mem [HISTORY_DEPTH];
	logic [23:0] alt_mem  [HISTORY_DEPTH];

	logic [7:0]          win_q;
	logic [31:0]         count_q, trail_q, cur_i_q;
	logic [SW-1:0]       nslot_q, tslot_q, cur_slot_q;
	logic [31:0]         t_now_q, t1_q, rd_t_q;
	logic signed [23:0]  a_now_q, a1_q, a0_q, rd_a_q;
	logic signed [33:0]  t_then_q;
	logic signed [41:0]  a_then_q;
	logic                short_q, zero_q;
	logic [31:0]         rate_q;
	logic                m_valid_q;
	logic [31:0]         m_data_q;
	logic [1:0]          m_user_q;

	logic                restart;
	logic [31:0]         i_new;
	logic [SW-1:0]       slot_new;
	logic [31:0]         oldest;
	logic [SW-1:0]       rd_addr;
	logic                rd_en;
	logic [11:0]         w;
	logic signed [33:0]  walk_diff, t_minus_w, dt;
	logic                md_start, md_done;
	logic signed [41:0]  md_x;
	logic signed [33:0]  md_y, md_d;
	logic signed [75:0]  md_q;
	logic signed [42:0]  q_lim;
	logic signed [43:0]  interp_sum;
	logic signed [41:0]  interp_alt;
	logic [31:0]         rate_sat;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SLOT_MAX) ? '0 : SW'(s + 1'b1);
	endfunction

	function automatic logic [SW-1:0] slot_dec(input logic [SW-1:0] s);
		return (s == '0) ? SLOT_MAX : SW'(s - 1'b1);
	endfunction

	assign restart  = start_in || (count_q == '0);
	assign i_new    = restart ? '0 : count_q;
	assign slot_new = restart ? '0 : nslot_q;
	assign oldest   = (cur_i_q >= DEPTH_M1) ? cur_i_q - DEPTH_M1 : '0;
	assign w        = {win_q, 4'b0000};

	assign rd_en   = cmd.rd_prev || cmd.rd_trail || cmd.rd_left;
	assign rd_addr = cmd.rd_prev ? slot_dec(cur_slot_q) :
		(cmd.rd_left ? slot_dec(tslot_q) : tslot_q);

	assign walk_diff = $signed({2'b00, t_now_q}) - $signed({2'b00, rd_t_q});
	assign t_minus_w = $signed({2'b00, t_now_q}) - $signed({22'd0, w});
	assign dt        = $signed({2'b00, t_now_q}) - t_then_q;

	assign md_start = cmd.interp_start || cmd.rate_start;
	assign md_x = cmd.interp_start ? 42'(a1_q - rd_a_q) : 42'($signed(a_now_q) - a_then_q);
	assign md_y = cmd.interp_start ? t_minus_w - $signed({2'b00, rd_t_q}) : wcr_pkg::RATE_SCALE;
	assign md_d = cmd.interp_start ? $signed({2'b00, t1_q}) - $signed({2'b00, rd_t_q}) : dt;

	wcr_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.x      (md_x),
		.y      (md_y),
		.d      (md_d),
		.done   (md_done),
		.q      (md_q)
	);

	always_comb begin
		if (md_q > 76'sd2199023255552) q_lim = 43'sd2199023255552;
		else if (md_q < -76'sd2199023255552) q_lim = -43'sd2199023255552;
		else q_lim = 43'(md_q);
		interp_sum = 44'(q_lim) + 44'(a0_q);
		if (interp_sum > 44'sd1099511627776) interp_alt = 42'sd1099511627776;
		else if (interp_sum < -44'sd1099511627776) interp_alt = -42'sd1099511627776;
		else interp_alt = 42'(interp_sum);
		if (md_q > 76'sd2147483647) rate_sat = 32'h7fffffff;
		else if (md_q < -76'sd2147483648) rate_sat = 32'h80000000;
		else rate_sat = 32'(md_q);
	end

	always_comb begin
		sts.first      = (cur_i_q == '0);
		sts.win_zero   = (win_q == '0);
		sts.walk_more  = (trail_q < cur_i_q) && (walk_diff > $signed({22'd0, w}));
		sts.at_edge    = (trail_q == '0) || (trail_q == oldest);
		sts.left_equal = (rd_t_q == t1_q);
		sts.dt_zero    = (dt == '0);
		sts.md_done    = md_done;
		sts.out_free   = !m_valid_q || m_tready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_mem[slot_new] <= t_in;
			alt_mem[slot_new]  <= a_in;
		end
		if (rd_en) begin
			rd_t_q <= time_mem[rd_addr];
			rd_a_q <= alt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= wcr_pkg::WINDOW_RESET;
			count_q   <= '0;
			nslot_q   <= '0;
			trail_q   <= '0;
			tslot_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) win_q <= cfg_wdata;
			if (cmd.load) begin
				count_q <= i_new + 32'd1;
				nslot_q <= slot_inc(slot_new);
				if (restart) begin
					trail_q <= '0;
					tslot_q <= '0;
				end
			end
			if (cmd.clamp && (trail_q < oldest)) begin
				trail_q <= oldest;
				tslot_q <= slot_inc(cur_slot_q);
			end
			if (cmd.walk_step) begin
				trail_q <= trail_q + 32'd1;
				tslot_q <= slot_inc(tslot_q);
			end
			if (cmd.out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_i_q    <= i_new;
			cur_slot_q <= slot_new;
			t_now_q    <= t_in;
			a_now_q    <= a_in;
			rate_q     <= '0;
			short_q    <= 1'b0;
			zero_q     <= 1'b0;
		end
		if (cmd.use_prev) begin
			t_then_q <= $signed({2'b00, rd_t_q});
			a_then_q <= 42'(rd_a_q);
		end
		if (cmd.take_t1) begin
			t1_q <= rd_t_q;
			a1_q <= rd_a_q;
		end
		if (cmd.use_t1) begin
			t_then_q <= $signed({2'b00, t1_q});
			a_then_q <= 42'(a1_q);
			short_q  <= (trail_q != '0);
		end
		if (cmd.left_take) begin
			t_then_q <= t_minus_w;
			a_then_q <= 42'(a1_q);
			a0_q     <= rd_a_q;
		end
		if (cmd.interp_done) a_then_q <= interp_alt;
		if (cmd.set_zero) begin
			zero_q <= 1'b1;
			rate_q <= '0;
		end
		if (cmd.rate_done) rate_q <= rate_sat;
		if (cmd.out_load) begin
			m_data_q <= rate_q;
			m_user_q <= {zero_q, short_q};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

endmodule

/* rtl/core/wcr_ctrl.sv */
module wcr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  wcr_pkg::sts_t  sts,
	output wcr_pkg::cmd_t  cmd
);

	wcr_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			wcr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = wcr_pkg::ST_SETUP;
				end
			end
			wcr_pkg::ST_SETUP: begin
				if (sts.first) begin
					state_nxt = wcr_pkg::ST_FIN;
				end else if (sts.win_zero) begin
					state_nxt = wcr_pkg::ST_PREV_RD;
				end else begin
					cmd.clamp = 1'b1;
					state_nxt = wcr_pkg::ST_WALK_RD;
				end
			end
			wcr_pkg::ST_PREV_RD: begin
				cmd.rd_prev = 1'b1;
				state_nxt   = wcr_pkg::ST_PREV_WT;
			end
			wcr_pkg::ST_PREV_WT: begin
				cmd.use_prev = 1'b1;
				state_nxt    = wcr_pkg::ST_RATE;
			end
			wcr_pkg::ST_WALK_RD: begin
				cmd.rd_trail = 1'b1;
				state_nxt    = wcr_pkg::ST_WALK_CHK;
			end
			wcr_pkg::ST_WALK_CHK: begin
				if (sts.walk_more) begin
					cmd.walk_step = 1'b1;
					state_nxt     = wcr_pkg::ST_WALK_RD;
				end else begin
					cmd.take_t1 = 1'b1;
					state_nxt   = wcr_pkg::ST_DECIDE;
				end
			end
			wcr_pkg::ST_DECIDE: begin
				if (sts.at_edge) begin
					cmd.use_t1 = 1'b1;
					state_nxt  = wcr_pkg::ST_RATE;
				end else begin
					cmd.rd_left = 1'b1;
					state_nxt   = wcr_pkg::ST_LEFT_WT;
				end
			end
			wcr_pkg::ST_LEFT_WT: begin
				cmd.left_take = 1'b1;
				if (sts.left_equal) begin
					state_nxt = wcr_pkg::ST_RATE;
				end else begin
					cmd.interp_start = 1'b1;
					state_nxt        = wcr_pkg::ST_INTERP_WT;
				end
			end
			wcr_pkg::ST_INTERP_WT: begin
				if (sts.md_done) begin
					cmd.interp_done = 1'b1;
					state_nxt       = wcr_pkg::ST_RATE;
				end
			end
			wcr_pkg::ST_RATE: begin
				if (sts.dt_zero) begin
					cmd.set_zero = 1'b1;
					state_nxt    = wcr_pkg::ST_FIN;
				end else begin
					cmd.rate_start = 1'b1;
					state_nxt      = wcr_pkg::ST_RATE_WT;
				end
			end
			wcr_pkg::ST_RATE_WT: begin
				if (sts.md_done) begin
					cmd.rate_done = 1'b1;
					state_nxt     = wcr_pkg::ST_FIN;
				end
			end
			wcr_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = wcr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = wcr_pkg::ST_IDLE;
		endcase
	end

endmodule

/* rtl/core/windowed_climb_rate.sv */
// the first sample of a track skips the rate pass; a zero window reads the previous sample;
// each trailing step and multiply-divide pass adds time; equal times skip interpolation
// throughput: one sample at a time, set by the shared 34-step multiply, 75-step divide unit
// and the one-read-per-cycle history memory walked by the trailing index
// reset: async low clears control, sample count, trailing index; window goes to 10 s
// history memory is not cleared, only slots written in the current track are read
`include "windowed_climb_rate_defines.svh"

module windowed_climb_rate #(
	parameter int HISTORY_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // sample_time[31:0], altitude[55:32]
	input  logic        s_tuser,   // track_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // rate[31:0]
	output logic [1:0]  m_tuser,   // window_short[0], zero_interval[1]
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata  // window_seconds
);

	wcr_pkg::cmd_t cmd;
	wcr_pkg::sts_t sts;

	wcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wcr_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.t_in      (s_tdata[31:0]),
		.a_in      (s_tdata[55:32]),
		.start_in  (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	`WCR_ASSERT_SAME(a_zero_rate, clk, arst_n, m_tvalid && m_tuser[1], m_tdata == 32'd0)
	`WCR_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

/* dv/wcr_checker.sv */
`timescale 1ns / 1ps

module wcr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_wen,
	input  logic [7:0]  cfg_wdata,
	output int          errors,
	output int          pending,
	output int          rates_checked
);

	localparam int DEPTH = 256;
	localparam longint ALT_CLAMP = 64'sd1099511627776;

	typedef struct packed {
		logic [31:0] rate;
		logic        short_hist;
		logic        zero_dt;
	} climb_t;

	logic [31:0] hist_time [DEPTH];
	int          hist_alt [DEPTH];
	logic [31:0] n_samples;
	logic [31:0] trail;
	logic [7:0]  win;
	climb_t      expected_climbs[$];

	function automatic climb_t climb_of(logic [31:0] t_now, logic [23:0] alt_raw,
			logic first);
		climb_t r;
		int a_now;
		logic [31:0] i, j, oldest;
		longint t_then, a_then, dt, w, t0, t1, a0, a1, v;
		a_now = $signed(alt_raw);
		r = '0;
		if (first) begin
			n_samples = 0;
			trail = 0;
		end
		if (n_samples == 0)
			trail = 0;
		i = n_samples;
		hist_time[i % DEPTH] = t_now;
		hist_alt[i % DEPTH] = a_now;
		n_samples = i + 1;
		if (i == 0)
			return r;
		if (win == 0) begin
			t_then = longint'(hist_time[(i - 1) % DEPTH]);
			a_then = hist_alt[(i - 1) % DEPTH];
		end else begin
			w = longint'(win) * 16;
			oldest = (i >= DEPTH - 1) ? i - (DEPTH - 1) : 0;
			j = trail;
			if (j > i) j = i;
			if (j < oldest) j = oldest;
			while (j < i && longint'(t_now) - longint'(hist_time[j % DEPTH]) > w)
				j++;
			trail = j;
			if (j == 0 || j - 1 < oldest) begin
				if (j != 0) r.short_hist = 1'b1;
				t_then = longint'(hist_time[j % DEPTH]);
				a_then = hist_alt[j % DEPTH];
			end else begin
				t0 = longint'(hist_time[(j - 1) % DEPTH]);
				t1 = longint'(hist_time[j % DEPTH]);
				a0 = hist_alt[(j - 1) % DEPTH];
				a1 = hist_alt[j % DEPTH];
				t_then = longint'(t_now) - w;
				if (t1 == t0) begin
					a_then = a1;
				end else begin
					a_then = a0 + ((t_then - t0) * (a1 - a0)) / (t1 - t0);
					if (a_then > ALT_CLAMP) a_then = ALT_CLAMP;
					if (a_then < -ALT_CLAMP) a_then = -ALT_CLAMP;
				end
			end
		end
		dt = longint'(t_now) - t_then;
		if (dt == 0) begin
			r.zero_dt = 1'b1;
		end else begin
			v = ((longint'(a_now) - a_then) * 960) / dt;
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			r.rate = v[31:0];
		end
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	assign pending = expected_climbs.size();

	always @(posedge clk or negedge arst_n) begin
		climb_t want;
		if (!arst_n) begin
			n_samples = 0;
			trail = 0;
			win = wcr_pkg::WINDOW_RESET;
			errors = 0;
			rates_checked = 0;
			expected_climbs.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_climbs.insert(expected_climbs.size(),
					climb_of(s_tdata[31:0], s_tdata[55:32], s_tuser));
			if (cfg_wen)
				win = cfg_wdata;
			if (m_tvalid && m_tready) begin
				rates_checked++;
				if (expected_climbs.size() == 0) begin
					report("unexpected transaction", m_tdata, 0);
				end else begin
					want = expected_climbs.pop_front();
					if (m_tdata !== want.rate)
						report("rate", m_tdata, want.rate);
					if (m_tuser[0] !== want.short_hist)
						report("window_short", m_tuser[0], want.short_hist);
					if (m_tuser[1] !== want.zero_dt)
						report("zero_interval", m_tuser[1], want.zero_dt);
				end
			end
		end
	end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // sample_time[31:0], altitude[55:32]
	logic        s_tuser = 0;    // track_start
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;        // rate[31:0]
	logic [1:0]  m_tuser;        // window_short[0], zero_interval[1]
	logic        cfg_wen = 0;
	logic [7:0]  cfg_wdata = '0;
	int          errors, pending, rates_checked;
	int          cycles = 0;
	int          samples_sent = 0;
	logic        steady = 0;
	logic [31:0] t_cur;
	logic [23:0] alt_cur;

	windowed_climb_rate u_top (.*);

	wcr_checker u_chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
		if (cycles > 3000000) begin
			$display("timeout");
			$display("windowed_climb_rate test failed");
			$finish;
		end
	end

	task automatic send_sample(logic [31:0] t, logic [23:0] alt, logic first);
		while (!steady && $urandom_range(99) < 36) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {alt, t};
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	task automatic set_window(logic [7:0] w);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (800) @(posedge clk);
		cfg_wen <= 1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_wen <= 0;
	endtask

	task automatic next_sample(logic first);
		int pick;
		pick = $urandom_range(99);
		if (first)
			t_cur = $urandom();
		else if (pick < 5)
			t_cur = t_cur;
		else if (pick < 10)
			t_cur = t_cur + $urandom_range(2000, 200000);
		else
			t_cur = t_cur + $urandom_range(1, 80);
		pick = $urandom_range(99);
		if (pick < 10)
			alt_cur = 24'($urandom());
		else if (pick < 15)
			alt_cur = $urandom_range(1) ? 24'h7fffff : 24'h800000;
		else
			alt_cur = 24'(alt_cur + $urandom_range(400) - 200);
		send_sample(t_cur, alt_cur, first);
	endtask

	task automatic run_tracks(int n);
		int len;
		while (n > 0) begin
			len = $urandom_range(1, 40);
			for (int k = 0; k < len && n > 0; k++, n--)
				next_sample(k == 0);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: first sample, altitude extremes, zero dt, equal times, time wrap
		steady = 1;
		send_sample(32'h0, 24'h800000, 1);
		send_sample(32'h10, 24'h7fffff, 0);
		send_sample(32'h10, 24'h000000, 0);
		send_sample(32'h20, 24'h000100, 0);
		send_sample(32'h20, 24'h000200, 0);
		send_sample(32'h200, 24'h7fffff, 0);
		send_sample(32'hffffffff, 24'h800000, 0);
		send_sample(32'h00000005, 24'h7fffff, 0);
		send_sample(32'hfffffff0, 24'h123456, 1);
		send_sample(32'hfffffff0, 24'hedcba9, 0);
		steady = 0;
		run_tracks(60);

		set_window(8'd0);
		send_sample(32'h1000, 24'h000000, 1);
		send_sample(32'h1000, 24'h000010, 0);
		send_sample(32'h1001, 24'h7fffff, 0);
		send_sample(32'h1002, 24'h800000, 0);
		run_tracks(60);

		// long track that outruns the history ring
		set_window(8'd255);
		steady = 1;
		t_cur = $urandom();
		alt_cur = 24'($urandom());
		send_sample(t_cur, alt_cur, 1);
		for (int k = 0; k < 299; k++) begin
			t_cur = t_cur + $urandom_range(0, 3);
			alt_cur = 24'(alt_cur + $urandom_range(64) - 32);
			send_sample(t_cur, alt_cur, 0);
		end
		steady = 0;

		set_window(8'd1);
		run_tracks(60);
		set_window(8'd37);
		run_tracks(60);

		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d samples over windows 10, 0, 255, 1, 37; %0d climb rates checked",
			samples_sent, rates_checked);
		if (errors == 0 && pending == 0)
			$display("windowed_climb_rate test passed");
		else
			$display("windowed_climb_rate test failed");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/wcr_pkg.sv
rtl/core/wcr_muldiv.sv
rtl/core/wcr_dpath.sv
rtl/core/wcr_ctrl.sv
rtl/core/windowed_climb_rate.sv
dv/wcr_checker.sv
dv/testbench.sv
